/* rtl/pls_pkg.sv */
// Shared types, widths and constants of the polyline subdivider.
package pls_pkg;

	localparam int COORD_W     = 32;
	localparam int MAG_W       = COORD_W + 1;
	localparam int SUB_W       = 6;
	localparam int MAX_SUB_DEF = 32;
	localparam int AXES        = 3;
	localparam int AX_W        = $clog2(AXES);

	localparam logic [SUB_W-1:0] SUB_RESET = SUB_W'(1);

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
		logic   final_vertex;
	} vtx_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
		logic   end_of_line;
	} pt_t;

	typedef struct packed {
		logic capture;
		logic load_div;
		logic step;
		logic commit;
	} lane_ctrl_t;

endpackage

/* rtl/pls_div.sv */
// Restoring divider, one quotient bit per cycle, shared by the three axes.
module pls_div import pls_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] dividend,
	input  logic [SUB_W-1:0] divisor,
	output logic             busy,
	output logic [MAG_W-1:0] quot,
	output logic [SUB_W-1:0] rem
);

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] work_q;
	logic [SUB_W-1:0] rem_q;
	logic [SUB_W-1:0] dv_q;
	logic [SUB_W:0]   trial;
	logic [SUB_W:0]   trial_sub;
	logic             ge;

	assign trial     = {rem_q, work_q[MAG_W-1]};
	assign ge        = trial >= {1'b0, dv_q};
	assign trial_sub = trial - {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(MAG_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dv_q   <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[MAG_W-2:0], ge};
			rem_q  <= ge ? trial_sub[SUB_W-1:0] : trial[SUB_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = work_q;
	assign rem  = rem_q;

endmodule

/* rtl/pls_lane.sv */
// One axis: held and current coordinate, step accumulator and point output.
module pls_lane import pls_pkg::*; (
	input  logic             clk,
	input  lane_ctrl_t       ctrl,
	input  coord_t           pos,
	input  logic [SUB_W-1:0] n,
	input  logic [MAG_W-1:0] quot,
	input  logic [SUB_W-1:0] rem,
	output logic [MAG_W-1:0] mag,
	output coord_t           prev,
	output coord_t           cur,
	output coord_t           point
);

	coord_t                  cur_q;
	coord_t                  prev_q;
	logic [MAG_W-1:0]        q0_q;
	logic [SUB_W-1:0]        r0_q;
	logic [MAG_W-1:0]        acc_q;
	logic [SUB_W-1:0]        accr_q;
	logic signed [MAG_W-1:0] diff;
	logic signed [MAG_W-1:0] prev_ext;
	logic signed [MAG_W-1:0] pt_wide;
	logic                    neg;
	logic [SUB_W:0]          rsum;
	logic [SUB_W:0]          rsum_sub;
	logic                    carry;

	assign prev_ext = MAG_W'(prev_q);
	assign diff     = MAG_W'(cur_q) - prev_ext;
	assign neg      = diff[MAG_W-1];
	assign mag      = neg ? MAG_W'(-diff) : MAG_W'(diff);

	// fractional part of j*|d|/n advances by r0 each step; wrap at n
	assign rsum     = {1'b0, accr_q} + {1'b0, r0_q};
	assign carry    = rsum >= {1'b0, n};
	assign rsum_sub = rsum - {1'b0, n};

	assign pt_wide = neg ? prev_ext - $signed(acc_q) : prev_ext + $signed(acc_q);

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cur_q  <= pos;
			acc_q  <= '0;
			accr_q <= '0;
		end else if (ctrl.step) begin
			acc_q  <= acc_q + q0_q + MAG_W'(carry);
			accr_q <= carry ? rsum_sub[SUB_W-1:0] : rsum[SUB_W-1:0];
		end
		if (ctrl.load_div) begin
			q0_q <= quot;
			r0_q <= rem;
		end
		if (ctrl.commit) begin
			prev_q <= cur_q;
		end
	end

	assign prev  = prev_q;
	assign cur   = cur_q;
	assign point = pt_wide[COORD_W-1:0];

endmodule

/* rtl/polyline_linear_subdivider.sv */
// Top level: sequencer, configuration register and output register of the subdivider.
// Throughput: one vertex at a time; in_ready is high only while the sequencer is idle.
// With a held vertex and n > 1 the sequencer sends the held vertex, runs three serial
// divisions (one per axis) and sends the intermediate points; a final vertex adds its own
// point. Intermediate points leave at one per cycle; a stalled output holds them.
// Reset (arst_n low, async): no vertex held, subdivisions = 1, no item pending.
module polyline_linear_subdivider import pls_pkg::*; #(
	parameter int MAX_SUBDIVISIONS = MAX_SUB_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  vtx_t             in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output pt_t              out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [SUB_W-1:0] cfg_data
);

	// sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_PREV     = 3'd1;
	localparam logic [2:0] S_DIV_GO   = 3'd2;
	localparam logic [2:0] S_DIV_WAIT = 3'd3;
	localparam logic [2:0] S_STEP     = 3'd4;
	localparam logic [2:0] S_MID      = 3'd5;
	localparam logic [2:0] S_LAST     = 3'd6;
	localparam logic [2:0] S_END      = 3'd7;

	localparam logic [SUB_W-1:0] MAX_LIM = SUB_W'(MAX_SUBDIVISIONS);
	localparam logic [AX_W-1:0]  AX_LAST = AX_W'(AXES - 1);

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [SUB_W-1:0] sub_q;
	logic [SUB_W-1:0] n_q;
	logic [SUB_W-1:0] n_eff;
	logic [SUB_W-1:0] cnt_q;
	logic [AX_W-1:0]  ax_q;
	logic             final_q;
	logic             have_prev_q;
	logic             out_valid_q;
	pt_t              out_q;
	pt_t              out_d;
	logic             out_load;
	logic             slot_free;
	logic             accept;

	// lane and divider wiring
	lane_ctrl_t       lane_ctrl [AXES];
	coord_t           lane_pos  [AXES];
	logic [MAG_W-1:0] lane_mag  [AXES];
	coord_t           lane_prev [AXES];
	coord_t           lane_cur  [AXES];
	coord_t           lane_pt   [AXES];
	logic             div_start;
	logic             div_busy;
	logic [MAG_W-1:0] div_quot;
	logic [SUB_W-1:0] div_rem;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || out_ready;

	// clamp the register: zero acts as one, large values saturate
	always_comb begin
		if (sub_q == '0) begin
			n_eff = SUB_W'(1);
		end else if (sub_q > MAX_LIM) begin
			n_eff = MAX_LIM;
		end else begin
			n_eff = sub_q;
		end
	end

	assign lane_pos[0] = in_data.pos_x;
	assign lane_pos[1] = in_data.pos_y;
	assign lane_pos[2] = in_data.pos_z;

	genvar a;
	generate
		for (a = 0; a < AXES; a++) begin : g_lane
			always_comb begin
				lane_ctrl[a].capture  = accept;
				lane_ctrl[a].load_div = (state_q == S_DIV_WAIT) && !div_busy
					&& (ax_q == AX_W'(a));
				lane_ctrl[a].step     = (state_q == S_STEP)
					|| ((state_q == S_MID) && slot_free);
				lane_ctrl[a].commit   = (state_q == S_END) && !final_q;
			end

			pls_lane u_lane (
				.clk   (clk),
				.ctrl  (lane_ctrl[a]),
				.pos   (lane_pos[a]),
				.n     (n_q),
				.quot  (div_quot),
				.rem   (div_rem),
				.mag   (lane_mag[a]),
				.prev  (lane_prev[a]),
				.cur   (lane_cur[a]),
				.point (lane_pt[a])
			);
		end
	endgenerate

	// one divider serves all axes in turn: |d| / n gives step quotient and remainder
	assign div_start = (state_q == S_DIV_GO);

	pls_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (lane_mag[ax_q]),
		.divisor  (n_q),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// next state and output register load
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		out_d    = out_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (have_prev_q) begin
						state_d = S_PREV;
					end else if (in_data.final_vertex) begin
						state_d = S_LAST;
					end else begin
						state_d = S_END;
					end
				end
			end
			S_PREV: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_d    = '{lane_prev[0], lane_prev[1], lane_prev[2], 1'b0};
					if (n_q > SUB_W'(1)) begin
						state_d = S_DIV_GO;
					end else if (final_q) begin
						state_d = S_LAST;
					end else begin
						state_d = S_END;
					end
				end
			end
			S_DIV_GO: begin
				state_d = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (!div_busy) begin
					state_d = (ax_q == AX_LAST) ? S_STEP : S_DIV_GO;
				end
			end
			S_STEP: begin
				state_d = S_MID;
			end
			S_MID: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_d    = '{lane_pt[0], lane_pt[1], lane_pt[2], 1'b0};
					if (cnt_q == SUB_W'(1)) begin
						state_d = final_q ? S_LAST : S_END;
					end
				end
			end
			S_LAST: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_d    = '{lane_cur[0], lane_cur[1], lane_cur[2], 1'b1};
					state_d  = S_END;
				end
			end
			S_END: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sub_q       <= SUB_RESET;
			n_q         <= SUB_W'(1);
			cnt_q       <= '0;
			ax_q        <= '0;
			final_q     <= 1'b0;
			have_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				sub_q <= cfg_data;
			end
			// latch the segment count and flags with the item
			if (accept) begin
				n_q     <= n_eff;
				cnt_q   <= n_eff - SUB_W'(1);
				ax_q    <= '0;
				final_q <= in_data.final_vertex;
			end
			// advance to the next axis after each division
			if ((state_q == S_DIV_WAIT) && !div_busy) begin
				ax_q <= ax_q + AX_W'(1);
			end
			if ((state_q == S_MID) && slot_free) begin
				cnt_q <= cnt_q - SUB_W'(1);
			end
			// keep the vertex for the next segment, or drop it at the end of a line
			if (state_q == S_END) begin
				have_prev_q <= !final_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* tb/tb.sv */
// Self-checking bench for the polyline subdivider: directed rows, then random polylines.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pls_pkg::*;

	// Worst case from accept to last point: three serial divisions plus the point burst.
	localparam int LATENCY        = 1 + 3 * (COORD_W + 3) + MAX_SUB_DEF + 3;
	localparam int QUIET          = LATENCY + 20;
	// Longest legal silence is a quiet pause plus a long stall on either side.
	localparam int WATCHDOG_LIMIT = 20 * LATENCY;
	localparam int RANDOM_ITEMS   = 480;
	localparam int PHASE_ITEMS    = 40;

	localparam coord_t C_MIN = coord_t'(32'h8000_0000);
	localparam coord_t C_MAX = coord_t'(32'h7fff_ffff);

	typedef enum logic {ROW_CFG, ROW_VTX} row_kind_t;

	// One directed step: either a register write or a vertex. Rows with
	// typed set carry their single expected point; the rest use the predictor.
	typedef struct {
		row_kind_t        kind;
		logic [SUB_W-1:0] sub;
		vtx_t             v;
		bit               typed;
		pt_t              want;
	} stim_row_t;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	vtx_t             in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	pt_t              out_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [SUB_W-1:0] cfg_data  = '0;

	// Predictor state: register mirror and the held vertex.
	logic [SUB_W-1:0] sub_reg = SUB_RESET;
	coord_t           held_x  = '0;
	coord_t           held_y  = '0;
	coord_t           held_z  = '0;
	bit               held_ok = 1'b0;

	pt_t pts_due[$];      // points still owed by the block, oldest first
	int  errors      = 0;
	int  idle_cycles = 0;
	int  stall_left  = 0;
	bit  calm        = 1'b0; // no gaps on either side while set

	polyline_linear_subdivider dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// a + trunc(j*(b-a)/n); SV signed division already rounds toward zero.
	function automatic coord_t lerp_axis(coord_t a, coord_t b, int j, int n);
		longint d;
		d = longint'(b) - longint'(a);
		return coord_t'(longint'(a) + (longint'(j) * d) / longint'(n));
	endfunction

	// Advance the polyline by one accepted vertex and queue the points it owes.
	function automatic void advance_polyline(vtx_t v, bit typed, pt_t want);
		int n;
		int j;
		n = int'(sub_reg);
		// Clamp the register: zero acts as one, large values saturate.
		if (n < 1)
			n = 1;
		if (n > MAX_SUB_DEF)
			n = MAX_SUB_DEF;
		if (typed) begin
			pts_due.push_back(want);
		end else begin
			if (held_ok) begin
				pts_due.push_back(pt_t'{held_x, held_y, held_z, 1'b0});
				for (j = 1; j < n; j++)
					pts_due.push_back(pt_t'{lerp_axis(held_x, v.pos_x, j, n),
						lerp_axis(held_y, v.pos_y, j, n),
						lerp_axis(held_z, v.pos_z, j, n), 1'b0});
			end
			if (v.final_vertex)
				pts_due.push_back(pt_t'{v.pos_x, v.pos_y, v.pos_z, 1'b1});
		end
		// A final vertex closes the polyline and drops the held vertex.
		if (v.final_vertex) begin
			held_x  = '0;
			held_y  = '0;
			held_z  = '0;
			held_ok = 1'b0;
		end else begin
			held_x  = v.pos_x;
			held_y  = v.pos_y;
			held_z  = v.pos_z;
			held_ok = 1'b1;
		end
	endfunction

	// Mostly no gap, some short, a few long.
	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Extremes, zero, full range, and small values near the origin.
	function automatic coord_t pick_coord();
		case ($urandom_range(0, 9))
			0: return C_MIN;
			1: return C_MAX;
			2, 3: return coord_t'($urandom);
			4: return '0;
			default: return coord_t'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
		endcase
	endfunction

	function automatic stim_row_t crow(logic [SUB_W-1:0] n);
		return '{ROW_CFG, n, vtx_t'('0), 1'b0, pt_t'('0)};
	endfunction

	function automatic stim_row_t vrow(coord_t x, coord_t y, coord_t z, logic f);
		return '{ROW_VTX, '0, vtx_t'{x, y, z, f}, 1'b0, pt_t'('0)};
	endfunction

	function automatic stim_row_t trow(coord_t x, coord_t y, coord_t z, logic f, pt_t want);
		return '{ROW_VTX, '0, vtx_t'{x, y, z, f}, 1'b1, want};
	endfunction

	// Present one vertex and hold it until accepted. Keep valid high only when
	// another vertex follows with no gap, so valid is never dropped and raised
	// in the same step.
	task automatic send_vertex(vtx_t v, bit more, bit typed, pt_t want);
		int g;
		in_valid <= 1'b1;
		in_data  <= v;
		do
			@(posedge clk);
		while (!in_ready);
		advance_polyline(v, typed, want);
		g = gap_len();
		if (g != 0 || !more)
			in_valid <= 1'b0;
		repeat (g) @(posedge clk);
	endtask

	// Write the register only once the block has drained; a held first vertex
	// leaves no point to wait on, so allow the full latency on top.
	task automatic write_subdiv(logic [SUB_W-1:0] n);
		while (pts_due.size() != 0)
			@(posedge clk);
		repeat (QUIET) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= n;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sub_reg = n;
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	// Output side: random stalls, none while calm.
	always @(posedge clk) begin
		if (calm) begin
			out_ready  <= 1'b1;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin : pick_stall
			int g;
			g = gap_len();
			out_ready  <= (g == 0);
			stall_left <= (g == 0) ? 0 : g - 1;
		end
	end

	// Compare each point taken from the block with the oldest one owed.
	always @(posedge clk) begin : take_points
		pt_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pts_due.size() == 0) begin
				errors++;
				$display("%0t ns: point with nothing expected, expected none got %h",
					$time, out_data);
			end else begin
				want = pts_due.pop_front();
				check_field("out_x", want.out_x, out_data.out_x);
				check_field("out_y", want.out_y, out_data.out_y);
				check_field("out_z", want.out_z, out_data.out_z);
				check_field("end_of_line", want.end_of_line, out_data.end_of_line);
			end
		end
	end

	// Abort when no item moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles, %0d points owed", $time,
				idle_cycles, pts_due.size());
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		stim_row_t        rows[$];
		vtx_t             v;
		logic [SUB_W-1:0] n;
		int               sent;
		int               k;
		int               len;
		int               p;
		bit               open_end;
		bit               phase_last;

		rows = '{
			// Reset value n = 1: a lone final vertex comes straight back.
			trow(C_MAX, C_MIN, 0, 1'b1, pt_t'{C_MAX, C_MIN, 0, 1'b1}),
			// First vertex is only held.
			vrow(10 << 16, -5, 7, 1'b0),
			// Pass-through: the held vertex leaves one vertex late.
			trow(C_MIN, C_MAX, -1, 1'b0, pt_t'{10 << 16, -5, 7, 1'b0}),
			vrow(1, 2, 3, 1'b1),
			// Zero acts as one.
			crow(0),
			vrow(100, 200, 300, 1'b0),
			vrow(-100, -200, -300, 1'b1),
			// Truncation toward zero on falling and rising axes.
			crow(4),
			vrow(0, 0, 0, 1'b0),
			vrow(1 << 16, -(3 << 16), 7, 1'b0),
			vrow(-7, 5, 2, 1'b1),
			// Full-range spans at the largest legal count.
			crow(32),
			vrow(C_MIN, C_MAX, C_MIN, 1'b0),
			vrow(C_MAX, C_MIN, C_MAX, 1'b1),
			// Counts above the maximum saturate.
			crow(33),
			vrow(C_MAX, 0, C_MIN, 1'b0),
			vrow(C_MIN, -1, C_MAX, 1'b1),
			crow(63),
			vrow(5, 5, 5, 1'b0),
			vrow(-5, -5, -5, 1'b1),
			crow(2),
			trow(32'h1234_5678, -1, 0, 1'b1, pt_t'{32'h1234_5678, -1, 0, 1'b1}),
			vrow(3, -3, 1, 1'b0),
			vrow(4, -4, 2, 1'b0),
			vrow(C_MAX, C_MIN, 0, 1'b1)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG)
				write_subdiv(rows[i].sub);
			else
				send_vertex(rows[i].v, i + 1 < rows.size() && rows[i + 1].kind == ROW_VTX,
					rows[i].typed, rows[i].want);
		end

		// Random phases: one register setting each, mostly small counts.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					case ($urandom_range(0, 4))
						0: n = 0;
						1: n = 1;
						2: n = 32;
						3: n = 33;
						default: n = 63;
					endcase
				end
				1: n = SUB_W'($urandom_range(0, 63));
				default: n = SUB_W'($urandom_range(1, 8));
			endcase
			write_subdiv(n);
			calm = ($urandom_range(0, 4) == 0);
			k = 0;
			while (k < PHASE_ITEMS) begin
				len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 6);
				// Sometimes leave the last polyline open across the register write.
				open_end = (k + len >= PHASE_ITEMS) && ($urandom_range(0, 3) == 0);
				for (p = 0; p < len; p++) begin
					v.pos_x        = pick_coord();
					v.pos_y        = pick_coord();
					v.pos_z        = pick_coord();
					v.final_vertex = (p == len - 1) && !open_end;
					phase_last     = (p == len - 1) && (k + len >= PHASE_ITEMS);
					send_vertex(v, !phase_last, 1'b0, pt_t'('0));
				end
				k    += len;
				sent += len;
			end
			calm = 1'b0;
		end

		// Drain, then give the block time to show any stray point.
		while (pts_due.size() != 0)
			@(posedge clk);
		repeat (QUIET) @(posedge clk);

		if (errors == 0 && pts_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("%0t ns: %0d mismatches, %0d points never arrived", $time, errors,
				pts_due.size());
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* polyline_linear_subdivider.f */
rtl/pls_pkg.sv
rtl/pls_div.sv
rtl/pls_lane.sv
rtl/polyline_linear_subdivider.sv
tb/tb.sv
